// ===== design/frsn_pkg.sv =====
`default_nettype none
package frsn_pkg;

   localparam logic [31:0] SEED_MAGIC = 32'h7EB5_3567;
   localparam logic [31:0] K_SCALE    = 32'h3FF8_44BA;
   localparam logic [31:0] K_OFFSET   = 32'h3FB7_D380;
   localparam logic [31:0] K_ONE      = 32'h3F80_0000;
   localparam logic [31:0] QNAN       = 32'h7FC0_0000;
   localparam logic [31:0] SIGN_MASK  = 32'h8000_0000;
   localparam logic [30:0] INF_MAG    = 31'h7F80_0000;

   // Register stages inside each arithmetic unit.
   localparam int MUL_STAGES = 3;
   localparam int ADD_STAGES = 4;

   function automatic logic is_nan(input logic [31:0] a);
      return a[30:0] > INF_MAG;
   endfunction

   // Right shift that ORs every bit shifted out into the lowest bit.
   function automatic logic [30:0] jam_shift(input logic [30:0] v, input logic [10:0] n);
      logic [30:0] mask;
      logic [30:0] r;
      mask = '0;
      if (n == 11'd0) begin
         r = v;
      end else if (n >= 11'd31) begin
         r = {30'b0, |v};
      end else begin
         mask = (31'd1 << n) - 31'd1;
         r = (v >> n) | {30'b0, |(v & mask)};
      end
      return r;
   endfunction

   function automatic logic [4:0] lzc24(input logic [23:0] v);
      logic [4:0] lz;
      lz = '0;
      for (int i = 0; i < 24; i++) begin
         if (v[i]) lz = 5'(23 - i);
      end
      return lz;
   endfunction

   function automatic logic [4:0] lzc31(input logic [30:0] v);
      logic [4:0] lz;
      lz = '0;
      for (int i = 0; i < 31; i++) begin
         if (v[i]) lz = 5'(30 - i);
      end
      return lz;
   endfunction

   // Rounds a significand with its top bit at bit 30 to nearest-even and packs it.
   // The value is sig * 2^(e - 157).
   function automatic logic [31:0] round_norm(input logic sign, input logic signed [10:0] e,
                                              input logic [30:0] sig);
      logic signed [10:0] ee;
      logic [30:0] sg;
      logic [31:0] sum;
      logic [24:0] s;
      logic [31:0] r;
      ee = e;
      sg = sig;
      sum = '0;
      s = '0;
      if (ee >= 11'sd255) begin
         r = {sign, INF_MAG};
      end else begin
         if (ee < 11'sd1) begin
            sg = jam_shift(sg, 11'(11'sd1 - ee));
            ee = '0;
         end
         sum = {1'b0, sg} + 32'h40;
         s = sum[31:7];
         if (sg[6:0] == 7'h40) s[0] = 1'b0;
         if (ee == 11'sd0) begin
            r = {sign, 7'b0, s[23:0]};
         end else begin
            if (s[24]) begin
               s = s >> 1;
               ee = ee + 11'sd1;
            end
            if (ee >= 11'sd255) r = {sign, INF_MAG};
            else r = {sign, ee[7:0], s[22:0]};
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== design/frsn_fmul.sv =====
`default_nettype none
module frsn_fmul (
   input  wire logic                             clock,
   input  wire logic [frsn_pkg::MUL_STAGES-1:0]  en,
   input  wire logic [31:0]                      a,
   input  wire logic [31:0]                      b,
   output logic [31:0]                           result
);

   // Stage 1: special operands and unpacking, subnormals normalized.
   logic              spec_in;
   logic [31:0]       sval_in;
   logic              sign_in;
   logic [4:0]        lza, lzb;
   logic [23:0]       mana_in, manb_in;
   logic signed [10:0] ea, eb, esum_in;

   logic              s1_spec_ff, s2_spec_ff;
   logic [31:0]       s1_sval_ff, s2_sval_ff;
   logic              s1_sign_ff, s2_sign_ff;
   logic signed [10:0] s1_esum_ff, s2_esum_ff;
   logic [23:0]       s1_mana_ff, s1_manb_ff;
   logic [47:0]       s2_prod_ff;
   logic [31:0]       result_ff;

   logic [30:0]       sig;
   logic signed [10:0] e3;
   logic [31:0]       result_in;

   always_comb begin
      sign_in = a[31] ^ b[31];
      spec_in = 1'b1;
      sval_in = '0;
      if (frsn_pkg::is_nan(a) || frsn_pkg::is_nan(b)) begin
         sval_in = frsn_pkg::QNAN;
      end else if (a[30:0] == frsn_pkg::INF_MAG || b[30:0] == frsn_pkg::INF_MAG) begin
         if (a[30:0] == 31'd0 || b[30:0] == 31'd0) sval_in = frsn_pkg::QNAN;
         else sval_in = {sign_in, frsn_pkg::INF_MAG};
      end else if (a[30:0] == 31'd0 || b[30:0] == 31'd0) begin
         sval_in = {sign_in, 31'd0};
      end else begin
         spec_in = 1'b0;
      end

      lza = frsn_pkg::lzc24({1'b0, a[22:0]});
      lzb = frsn_pkg::lzc24({1'b0, b[22:0]});
      if (a[30:23] == 8'd0) begin
         mana_in = {1'b0, a[22:0]} << lza;
         ea = 11'sd1 - $signed({6'b0, lza});
      end else begin
         mana_in = {1'b1, a[22:0]};
         ea = $signed({3'b0, a[30:23]});
      end
      if (b[30:23] == 8'd0) begin
         manb_in = {1'b0, b[22:0]} << lzb;
         eb = 11'sd1 - $signed({6'b0, lzb});
      end else begin
         manb_in = {1'b1, b[22:0]};
         eb = $signed({3'b0, b[30:23]});
      end
      esum_in = ea + eb;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_spec_ff <= spec_in;
         s1_sval_ff <= sval_in;
         s1_sign_ff <= sign_in;
         s1_esum_ff <= esum_in;
         s1_mana_ff <= mana_in;
         s1_manb_ff <= manb_in;
      end
   end

   // Stage 2: significand product.
   always_ff @(posedge clock) begin
      if (en[1]) begin
         s2_spec_ff <= s1_spec_ff;
         s2_sval_ff <= s1_sval_ff;
         s2_sign_ff <= s1_sign_ff;
         s2_esum_ff <= s1_esum_ff;
         s2_prod_ff <= 48'(s1_mana_ff) * 48'(s1_manb_ff);
      end
   end

   // Stage 3: the product of normalized significands is never below 2^46.
   always_comb begin
      if (s2_prod_ff[47]) begin
         sig = s2_prod_ff[47:17] | {30'b0, |s2_prod_ff[16:0]};
         e3 = s2_esum_ff - 11'sd126;
      end else begin
         sig = s2_prod_ff[46:16] | {30'b0, |s2_prod_ff[15:0]};
         e3 = s2_esum_ff - 11'sd127;
      end
      result_in = s2_spec_ff ? s2_sval_ff : frsn_pkg::round_norm(s2_sign_ff, e3, sig);
   end

   always_ff @(posedge clock) begin
      if (en[2]) result_ff <= result_in;
   end

   assign result = result_ff;

endmodule
`default_nettype wire

// ===== design/frsn_fadd.sv =====
`default_nettype none
module frsn_fadd (
   input  wire logic                             clock,
   input  wire logic [frsn_pkg::ADD_STAGES-1:0]  en,
   input  wire logic [31:0]                      a,
   input  wire logic [31:0]                      b,
   output logic [31:0]                           result
);

   logic              spec_in;
   logic [31:0]       sval_in;
   logic [31:0]       big, sml;
   logic [7:0]        ebig, esml;

   logic              s1_spec_ff, s2_spec_ff, s3_spec_ff;
   logic [31:0]       s1_sval_ff, s2_sval_ff, s3_sval_ff;
   logic              s1_sign_ff, s2_sign_ff, s3_sign_ff;
   logic              s1_sub_ff;
   logic [7:0]        s1_exp_ff, s1_diff_ff;
   logic [30:0]       s1_fa_ff, s1_fb_ff;
   logic signed [10:0] s2_exp_ff, s3_exp_ff;
   logic [30:0]       s2_sum_ff, s3_sig_ff;
   logic [31:0]       result_ff;

   logic [30:0]       fb_al;
   logic [31:0]       sum32;
   logic [30:0]       sum_in;
   logic signed [10:0] exp2_in;
   logic              spec2_in;
   logic [31:0]       sval2_in;
   logic [4:0]        lz;

   // Stage 1: special operands, order by magnitude, unpack.
   always_comb begin
      spec_in = 1'b1;
      sval_in = '0;
      if (frsn_pkg::is_nan(a) || frsn_pkg::is_nan(b)) begin
         sval_in = frsn_pkg::QNAN;
      end else if (a[30:0] == frsn_pkg::INF_MAG || b[30:0] == frsn_pkg::INF_MAG) begin
         if (a[30:0] == b[30:0] && a[31] != b[31]) sval_in = frsn_pkg::QNAN;
         else sval_in = (a[30:0] == frsn_pkg::INF_MAG) ? a : b;
      end else if (a[30:0] == 31'd0 && b[30:0] == 31'd0) begin
         sval_in = {a[31] & b[31], 31'd0};
      end else if (a[30:0] == 31'd0) begin
         sval_in = b;
      end else if (b[30:0] == 31'd0) begin
         sval_in = a;
      end else begin
         spec_in = 1'b0;
      end
      if (b[30:0] > a[30:0]) begin
         big = b;
         sml = a;
      end else begin
         big = a;
         sml = b;
      end
      ebig = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      esml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_spec_ff <= spec_in;
         s1_sval_ff <= sval_in;
         s1_sign_ff <= big[31];
         s1_sub_ff  <= big[31] ^ sml[31];
         s1_exp_ff  <= ebig;
         s1_diff_ff <= ebig - esml;
         s1_fa_ff   <= {big[30:23] != 8'd0, big[22:0], 7'b0};
         s1_fb_ff   <= {sml[30:23] != 8'd0, sml[22:0], 7'b0};
      end
   end

   // Stage 2: align the smaller operand, then add or subtract.
   always_comb begin
      fb_al = frsn_pkg::jam_shift(s1_fb_ff, {3'b0, s1_diff_ff});
      spec2_in = s1_spec_ff;
      sval2_in = s1_sval_ff;
      sum32 = '0;
      if (s1_sub_ff) begin
         sum_in = s1_fa_ff - fb_al;
         exp2_in = $signed({3'b0, s1_exp_ff});
         // Exact cancellation gives positive zero.
         if (!s1_spec_ff && sum_in == 31'd0) begin
            spec2_in = 1'b1;
            sval2_in = '0;
         end
      end else begin
         sum32 = {1'b0, s1_fa_ff} + {1'b0, fb_al};
         if (sum32[31]) begin
            sum_in = sum32[31:1] | {30'b0, sum32[0]};
            exp2_in = $signed({3'b0, s1_exp_ff}) + 11'sd1;
         end else begin
            sum_in = sum32[30:0];
            exp2_in = $signed({3'b0, s1_exp_ff});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s2_spec_ff <= spec2_in;
         s2_sval_ff <= sval2_in;
         s2_sign_ff <= s1_sign_ff;
         s2_exp_ff  <= exp2_in;
         s2_sum_ff  <= sum_in;
      end
   end

   // Stage 3: leading-zero count and normalizing shift.
   assign lz = frsn_pkg::lzc31(s2_sum_ff);

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s3_spec_ff <= s2_spec_ff;
         s3_sval_ff <= s2_sval_ff;
         s3_sign_ff <= s2_sign_ff;
         s3_exp_ff  <= s2_exp_ff - $signed({6'b0, lz});
         s3_sig_ff  <= s2_sum_ff << lz;
      end
   end

   // Stage 4: round and pack.
   always_ff @(posedge clock) begin
      if (en[3]) begin
         result_ff <= s3_spec_ff ? s3_sval_ff
                                 : frsn_pkg::round_norm(s3_sign_ff, s3_exp_ff, s3_sig_ff);
      end
   end

   assign result = result_ff;

endmodule
`default_nettype wire

// ===== design/float_reciprocal_seed_newton.sv =====
// Approximate binary32 reciprocal: magic-constant seed and one refinement sequence.
// There are 25 register stages; throughput is one item per cycle while the output is
// not stalled, and seven floating-point units in series set the depth.
// A stall holds only the stages behind a waiting item, so bubbles are squeezed out.
// Synchronous reset clears the stage valid bits; data registers are not reset.
`default_nettype none
module float_reciprocal_seed_newton (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_value_bits,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_result_bits
);

   localparam int ST_M1  = 1;
   localparam int ST_A1  = ST_M1 + frsn_pkg::MUL_STAGES;
   localparam int ST_M3  = ST_A1 + frsn_pkg::ADD_STAGES;
   localparam int ST_M4  = ST_M3 + frsn_pkg::MUL_STAGES;
   localparam int ST_A2  = ST_M4 + frsn_pkg::MUL_STAGES;
   localparam int ST_M5  = ST_A2 + frsn_pkg::ADD_STAGES;
   localparam int ST_A3  = ST_M5 + frsn_pkg::MUL_STAGES;
   localparam int NSTAGE = ST_A3 + frsn_pkg::ADD_STAGES;

   logic [NSTAGE-1:0] v_ff;
   logic [NSTAGE-1:0] v_src;
   logic [NSTAGE:0]   en;

   logic [31:0] xd_ff   [0:ST_M4-1];
   logic [31:0] seed_ff;
   logic [31:0] t0d_ff  [ST_A1:ST_M3-1];
   logic [31:0] yd_ff   [ST_M4:ST_A3-1];

   logic [31:0] t1_m1, t0_m2, t1_a1, y_m3, t1_m4, r_a2, t0_m5;

   // A stage may load when it is empty or when its item moves on.
   always_comb begin
      en[NSTAGE] = !rsp_stall;
      for (int k = NSTAGE - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign v_src = {v_ff[NSTAGE-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NSTAGE; k++) begin
            if (en[k]) v_ff[k] <= v_src[k];
         end
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = v_ff[NSTAGE-1];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         xd_ff[0] <= req_value_bits;
         seed_ff  <= frsn_pkg::SEED_MAGIC - req_value_bits;
      end
   end

   genvar g;
   generate
      for (g = 1; g < ST_M4; g++) begin : g_xd
         always_ff @(posedge clock) begin
            if (en[g]) xd_ff[g] <= xd_ff[g-1];
         end
      end
      for (g = ST_A1; g < ST_M3; g++) begin : g_t0d
         always_ff @(posedge clock) begin
            if (en[g]) t0d_ff[g] <= (g == ST_A1) ? t0_m2 : t0d_ff[(g == ST_A1) ? g : g-1];
         end
      end
      for (g = ST_M4; g < ST_A3; g++) begin : g_yd
         always_ff @(posedge clock) begin
            if (en[g]) yd_ff[g] <= (g == ST_M4) ? y_m3 : yd_ff[(g == ST_M4) ? g : g-1];
         end
      end
   endgenerate

   frsn_fmul u_mul1 (
      .clock (clock), .en (en[ST_M1 +: frsn_pkg::MUL_STAGES]),
      .a (xd_ff[0] ^ frsn_pkg::SIGN_MASK), .b (seed_ff), .result (t1_m1)
   );

   frsn_fmul u_mul2 (
      .clock (clock), .en (en[ST_M1 +: frsn_pkg::MUL_STAGES]),
      .a (frsn_pkg::K_SCALE), .b (seed_ff), .result (t0_m2)
   );

   frsn_fadd u_add1 (
      .clock (clock), .en (en[ST_A1 +: frsn_pkg::ADD_STAGES]),
      .a (t1_m1), .b (frsn_pkg::K_OFFSET), .result (t1_a1)
   );

   frsn_fmul u_mul3 (
      .clock (clock), .en (en[ST_M3 +: frsn_pkg::MUL_STAGES]),
      .a (t0d_ff[ST_M3-1]), .b (t1_a1), .result (y_m3)
   );

   frsn_fmul u_mul4 (
      .clock (clock), .en (en[ST_M4 +: frsn_pkg::MUL_STAGES]),
      .a (xd_ff[ST_M4-1] ^ frsn_pkg::SIGN_MASK), .b (y_m3), .result (t1_m4)
   );

   frsn_fadd u_add2 (
      .clock (clock), .en (en[ST_A2 +: frsn_pkg::ADD_STAGES]),
      .a (t1_m4), .b (frsn_pkg::K_ONE), .result (r_a2)
   );

   frsn_fmul u_mul5 (
      .clock (clock), .en (en[ST_M5 +: frsn_pkg::MUL_STAGES]),
      .a (yd_ff[ST_M5-1]), .b (r_a2), .result (t0_m5)
   );

   frsn_fadd u_add3 (
      .clock (clock), .en (en[ST_A3 +: frsn_pkg::ADD_STAGES]),
      .a (t0_m5), .b (yd_ff[ST_A3-1]), .result (rsp_result_bits)
   );

endmodule
`default_nettype wire

// ===== design/frsn_checker.sv =====
`default_nettype none
module frsn_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [31:0] req_value_bits,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_result_bits
);

   localparam int DEPTH = 25;

   logic [5:0] cnt_ff;
   logic [5:0] cnt_in;
   logic       req_fire, rsp_fire;

   assign req_fire = req_valid && !req_stall;
   assign rsp_fire = rsp_valid && !rsp_stall;

   always_comb begin
      cnt_in = cnt_ff;
      if (req_fire && !rsp_fire) cnt_in = cnt_ff + 6'd1;
      else if (!req_fire && rsp_fire) cnt_in = cnt_ff - 6'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
   end

   // A result is never shown without an item in flight.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cnt_ff != 6'd0) else $error("result without an item in flight");

   // The pipeline never holds more items than it has stages.
   a_depth: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 6'(DEPTH)) else $error("more items in flight than stages");

   // Input is only held back when the output is blocked.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall) else $error("input stalled while output is free");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_bits))
      else $error("stalled result changed");

endmodule

bind float_reciprocal_seed_newton frsn_checker u_frsn_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_value_bits  (req_value_bits),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_result_bits (rsp_result_bits)
);
`default_nettype wire
